@@ rtl/rdtg_pkg.sv @@
// ----------------------------------------------------------------------------
// rdtg_pkg
// Shared types and constants of the rate damping torque unit.
// ----------------------------------------------------------------------------
package rdtg_pkg;

  // Register index codes on the configuration port
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t CFG_INERTIA_ROW_X = 3'd0;
  localparam cfg_index_t CFG_INERTIA_ROW_Y = 3'd1;
  localparam cfg_index_t CFG_INERTIA_ROW_Z = 3'd2;
  localparam cfg_index_t CFG_DAMPING_GAINS = 3'd3;
  localparam cfg_index_t CFG_TARGET_SPIN_X = 3'd4;

  localparam int unsigned FIX_W  = 20;
  localparam int unsigned WORD_W = 3 * FIX_W;

  // Rates, gains, inertia: 2^-16 LSB
  typedef logic signed [FIX_W-1:0]  fix20_t;
  typedef logic        [WORD_W-1:0] cfg_word_t;
  // Angular momentum, 2^-32 LSB
  typedef logic signed [41:0]       mom_t;
  // Gain times rate error, 2^-32 LSB
  typedef logic signed [40:0]       damp_t;
  // One cross product term, 2^-48 LSB
  typedef logic signed [61:0]       term_t;
  // Torque, 2^-24 Nm LSB
  typedef logic signed [31:0]       torque_t;

  typedef fix20_t [2:0]             rate_vec_t;
  typedef mom_t   [2:0]             mom_vec_t;
  typedef damp_t  [2:0]             damp_vec_t;
  typedef term_t  [2:0]             term_vec_t;
  typedef torque_t [2:0]            torque_vec_t;

  // Decoded configuration as seen by the datapath
  typedef struct packed {
    fix20_t [2:0][2:0] inertia;   // [row][column]
    fix20_t [2:0]      gain;
    fix20_t            target;
  } cfg_t;

  // 0.034907 rad/s at 2^-16 LSB
  localparam fix20_t  TARGET_SPIN_RESET = 20'sd2288;

  localparam logic signed [63:0] ROUND_HALF = 64'sd8388608;
  localparam torque_t TORQUE_MAX = 32'sh7FFFFFFF;
  localparam torque_t TORQUE_MIN = 32'sh80000000;

endpackage

@@ rtl/rdtg_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rdtg_cfg_regs
// Configuration register file: inertia rows, damping gains and target spin.
// ----------------------------------------------------------------------------
module rdtg_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  rdtg_pkg::cfg_index_t  cfg_index,
  input  rdtg_pkg::cfg_word_t   cfg_wdata,
  output rdtg_pkg::cfg_t        cfg
);

  rdtg_pkg::cfg_word_t inertia_row [3];
  rdtg_pkg::cfg_word_t gains;
  rdtg_pkg::fix20_t    target;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_row[0] <= '0;
      inertia_row[1] <= '0;
      inertia_row[2] <= '0;
      gains          <= '0;
      target         <= rdtg_pkg::TARGET_SPIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rdtg_pkg::CFG_INERTIA_ROW_X: inertia_row[0] <= cfg_wdata;
        rdtg_pkg::CFG_INERTIA_ROW_Y: inertia_row[1] <= cfg_wdata;
        rdtg_pkg::CFG_INERTIA_ROW_Z: inertia_row[2] <= cfg_wdata;
        rdtg_pkg::CFG_DAMPING_GAINS: gains          <= cfg_wdata;
        rdtg_pkg::CFG_TARGET_SPIN_X: target <= cfg_wdata[rdtg_pkg::FIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the 20-bit fields, column 0 / axis x in the low bits
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cfg.inertia[r][c] = inertia_row[r][c*rdtg_pkg::FIX_W +: rdtg_pkg::FIX_W];
      end
      cfg.gain[r] = gains[r*rdtg_pkg::FIX_W +: rdtg_pkg::FIX_W];
    end
    cfg.target = target;
  end

endmodule

@@ rtl/rdtg_momentum.sv @@
// ----------------------------------------------------------------------------
// rdtg_momentum
// Stages 1-2: inertia products and rate error, then H = I*w and K*err.
// ----------------------------------------------------------------------------
module rdtg_momentum (
  input  logic                  clk,
  input  logic                  rst,
  input  rdtg_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rdtg_pkg::rate_vec_t   w_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rdtg_pkg::rate_vec_t   w_out,
  output rdtg_pkg::mom_vec_t    h_out,
  output rdtg_pkg::damp_vec_t   damp_out
);

  logic                     v1, v2, en1, en2;
  logic signed [39:0]       prod1 [3][3];
  logic signed [20:0]       err1  [3];
  logic signed [20:0]       err_in [3];
  rdtg_pkg::rate_vec_t      w1;

  // Stage enables: a stage loads when empty or when its beat moves on
  assign en2       = !v2 || out_ready;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  // Rate error against (target, 0, 0)
  always_comb begin
    err_in[0] = 21'($signed(cfg.target)) - 21'($signed(w_in[0]));
    err_in[1] = 21'sd0 - 21'($signed(w_in[1]));
    err_in[2] = 21'sd0 - 21'($signed(w_in[2]));
  end

  // Stage 1: nine inertia element products
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      w1 <= w_in;
      for (int r = 0; r < 3; r++) begin
        err1[r] <= err_in[r];
        for (int c = 0; c < 3; c++) begin
          prod1[r][c] <= $signed(cfg.inertia[r][c]) * $signed(w_in[c]);
        end
      end
    end
  end

  // Stage 2: row sums and damping term
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      w_out <= w1;
      for (int r = 0; r < 3; r++) begin
        h_out[r]    <= 42'(prod1[r][0]) + 42'(prod1[r][1]) + 42'(prod1[r][2]);
        damp_out[r] <= $signed(cfg.gain[r]) * err1[r];
      end
    end
  end

endmodule

@@ rtl/rdtg_gyro.sv @@
// ----------------------------------------------------------------------------
// rdtg_gyro
// Stages 3-4: the six w x H terms, each as two partial products of H.
// ----------------------------------------------------------------------------
module rdtg_gyro (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rdtg_pkg::rate_vec_t   w_in,
  input  rdtg_pkg::mom_vec_t    h_in,
  input  rdtg_pkg::damp_vec_t   damp_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rdtg_pkg::term_vec_t   pos_out,
  output rdtg_pkg::term_vec_t   neg_out,
  output rdtg_pkg::damp_vec_t   damp_out
);

  logic                     v3, v4, en3, en4;
  // Operands per axis r: positive term w[a]*h[b], negative term w[b]*h[a]
  rdtg_pkg::fix20_t         op_w [6];
  rdtg_pkg::mom_t           op_h [6];
  logic signed [41:0]       lo3  [6];
  logic signed [40:0]       hi3  [6];
  rdtg_pkg::damp_vec_t      damp3;

  assign en4       = !v4 || out_ready;
  assign en3       = !v3 || en4;
  assign in_ready  = en3;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en3) v3 <= in_valid;
      if (en4) v4 <= v3;
    end
  end

  // Cross product operand routing: x = wy*hz - wz*hy, and so on
  always_comb begin
    op_w[0] = w_in[1]; op_h[0] = h_in[2];
    op_w[1] = w_in[2]; op_h[1] = h_in[1];
    op_w[2] = w_in[2]; op_h[2] = h_in[0];
    op_w[3] = w_in[0]; op_h[3] = h_in[2];
    op_w[4] = w_in[0]; op_h[4] = h_in[1];
    op_w[5] = w_in[1]; op_h[5] = h_in[0];
  end

  // Stage 3: H split at bit 21 into an unsigned low and a signed high part
  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      damp3 <= damp_in;
      for (int k = 0; k < 6; k++) begin
        lo3[k] <= $signed(op_w[k]) * $signed({1'b0, op_h[k][20:0]});
        hi3[k] <= $signed(op_w[k]) * $signed(op_h[k][41:21]);
      end
    end
  end

  // Stage 4: recombine the partial products
  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      damp_out <= damp3;
      for (int r = 0; r < 3; r++) begin
        pos_out[r] <= (62'(hi3[2*r]) <<< 21) + 62'(lo3[2*r]);
        neg_out[r] <= (62'(hi3[2*r+1]) <<< 21) + 62'(lo3[2*r+1]);
      end
    end
  end

endmodule

@@ rtl/rdtg_torque.sv @@
// ----------------------------------------------------------------------------
// rdtg_torque
// Stages 5-6: torque sum with rounding, then scaling and saturation.
// ----------------------------------------------------------------------------
module rdtg_torque (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rdtg_pkg::term_vec_t   pos_in,
  input  rdtg_pkg::term_vec_t   neg_in,
  input  rdtg_pkg::damp_vec_t   damp_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rdtg_pkg::torque_vec_t torque,
  output logic                  clipped
);

  logic                     v5, v6, en5, en6;
  logic signed [63:0]       sum5 [3];
  logic signed [39:0]       scaled [3];
  rdtg_pkg::torque_vec_t    sat_val;
  logic [2:0]               hit;

  assign en6       = !v6 || out_ready;
  assign en5       = !v5 || en6;
  assign in_ready  = en5;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en5) v5 <= in_valid;
      if (en6) v6 <= v5;
    end
  end

  // Stage 5: damping moved to 2^-48, plus gyro term, plus half an output LSB
  always_ff @(posedge clk) begin
    if (en5 && in_valid) begin
      for (int r = 0; r < 3; r++) begin
        sum5[r] <= (64'(damp_in[r]) <<< 16) + 64'(pos_in[r]) - 64'(neg_in[r])
                   + rdtg_pkg::ROUND_HALF;
      end
    end
  end

  // Floor to 2^-24 and clamp to 32 bits
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      scaled[r] = $signed(sum5[r][63:24]);
      if (!scaled[r][39] && (|scaled[r][38:31])) begin
        sat_val[r] = rdtg_pkg::TORQUE_MAX;
        hit[r]     = 1'b1;
      end else if (scaled[r][39] && !(&scaled[r][38:31])) begin
        sat_val[r] = rdtg_pkg::TORQUE_MIN;
        hit[r]     = 1'b1;
      end else begin
        sat_val[r] = scaled[r][31:0];
        hit[r]     = 1'b0;
      end
    end
  end

  // Stage 6: output register
  always_ff @(posedge clk) begin
    if (en6 && v5) begin
      torque  <= sat_val;
      clipped <= |hit;
    end
  end

endmodule

@@ rtl/rate_damping_torque_gyro_comp_unit.sv @@
// ----------------------------------------------------------------------------
// rate_damping_torque_gyro_comp_unit
// Command torque T = K*(target - w) + w x (I*w) from a body rate sample.
// ----------------------------------------------------------------------------
// Six-stage pipeline: one rate beat is taken every clock unless stalled, via
// inertia product, gain and momentum products (H split into two partial
// products), final sum, then scaling and clamp. Each stage holds its beat
// under output backpressure and empty stages close up, so the input stays
// ready while the pipe has room. Torque is rounded to nearest (ties up) at
// 2^-24 Nm and saturated to 32 bits; clipped flags any saturated axis.
// The user must write configuration only while idle; it is not enforced.
module rate_damping_torque_gyro_comp_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [59:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [19:0]    rate_x,
  input  logic signed [19:0]    rate_y,
  input  logic signed [19:0]    rate_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    torque_x,
  output logic signed [31:0]    torque_y,
  output logic signed [31:0]    torque_z,
  output logic                  clipped
);

  rdtg_pkg::cfg_t         cfg;
  rdtg_pkg::rate_vec_t    w_in, w_m;
  rdtg_pkg::mom_vec_t     h_m;
  rdtg_pkg::damp_vec_t    damp_m, damp_g;
  rdtg_pkg::term_vec_t    pos_g, neg_g;
  rdtg_pkg::torque_vec_t  torque;
  logic                   m_valid, m_ready, g_valid, g_ready;

  assign w_in[0] = rate_x;
  assign w_in[1] = rate_y;
  assign w_in[2] = rate_z;

  // Configuration registers
  rdtg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Momentum and damping stages
  rdtg_momentum u_mom (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .w_in      (w_in),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .w_out     (w_m),
    .h_out     (h_m),
    .damp_out  (damp_m)
  );

  // Gyroscopic term stages
  rdtg_gyro u_gyro (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .w_in      (w_m),
    .h_in      (h_m),
    .damp_in   (damp_m),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .pos_out   (pos_g),
    .neg_out   (neg_g),
    .damp_out  (damp_g)
  );

  // Sum, round and clamp stages
  rdtg_torque u_torque (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .pos_in    (pos_g),
    .neg_in    (neg_g),
    .damp_in   (damp_g),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .torque    (torque),
    .clipped   (clipped)
  );

  assign torque_x = torque[0];
  assign torque_y = torque[1];
  assign torque_z = torque[2];

endmodule
